// ----- src/tcw_pkg.sv -----
package tcw_pkg;

  // default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  localparam int CELL_W = 16;

  // item kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // control characters
  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_RETURN  = 8'd13;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  localparam int TAB_STOP = 4;

  localparam logic [7:0]        ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {ATTR_RESET, CHAR_SPACE};

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_GLYPH,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_READ,
    S_FINISH
  } state_t;

endpackage

// ----- src/tcw_in_if.sv -----
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_column;

  modport source (output valid, kind, char_code, read_row, read_column, input ready);
  modport sink   (input valid, kind, char_code, read_row, read_column, output ready);
endinterface

// ----- src/tcw_out_if.sv -----
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_column;

  modport source (output valid, cell_value, cursor_row, cursor_column, input ready);
  modport sink   (input valid, cell_value, cursor_row, cursor_column, output ready);
endinterface

// ----- src/tcw_ram.sv -----
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/text_console_writer.sv -----
// Text console writer: keeps a SCREEN_HEIGHT x SCREEN_WIDTH screen of 16-bit cells
// (attribute in the high byte, character in the low byte) in one block RAM, plus a
// cursor. Each input beat puts a character (newline, carriage return and tab are
// interpreted, code 0 is ignored), clears the screen, or reads one cell; every beat
// yields exactly one result beat carrying the cell read (zero for other kinds) and
// the cursor after the item. A column equal to SCREEN_WIDTH means a wrap is pending.
// Handshake: one beat at a time. A result still waiting on the output holds the
// block in its finish state. Everything is bound by the single RAM write port,
// one cell per cycle: a scroll primes the read, copies every row up, then blanks
// the bottom row, and a clear blanks every cell. After reset the block sweeps the
// RAM with blank cells (attribute 07) before taking its first beat; attribute
// writes on cfg_we are taken at any time, including during that sweep.
// The next beat is accepted while a result still waits on the output register.
module text_console_writer #(
  parameter int SCREEN_WIDTH  = tcw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tcw_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  tcw_in_if.sink     item,
  tcw_out_if.source  result
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(SCREEN_HEIGHT);
  localparam int CW    = $clog2(SCREEN_WIDTH + 1);
  localparam int MW    = AW + 9;  // wide enough for row*width+col of any input

  localparam logic [RW-1:0] LAST_ROW  = RW'(SCREEN_HEIGHT - 1);
  localparam logic [CW-1:0] WRAP_COL  = CW'(SCREEN_WIDTH);
  localparam logic [PW-1:0] PTR_ROW1  = PW'(SCREEN_WIDTH);
  localparam logic [PW-1:0] PTR_END   = PW'(CELLS);
  localparam logic [PW-1:0] PTR_LAST  = PW'(CELLS - 1);
  localparam logic [PW-1:0] PTR_BOTTOM = PW'(CELLS - SCREEN_WIDTH);

  tcw_pkg::state_t state, state_next;

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [2:0]    glyph_left;      // cells still to write for this item
  logic [7:0]    glyph_char;
  logic [PW-1:0] ptr;             // sweep pointer for init/scroll/blank/clear
  logic          in_range;
  logic [15:0]   read_cell;
  logic [7:0]    attribute;

  logic          out_valid;
  logic [15:0]   out_cell;
  logic [4:0]    out_row;
  logic [6:0]    out_col;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] req_addr;
  logic          accept;
  logic          out_free;

  assign cur_addr = AW'(MW'(row) * MW'(SCREEN_WIDTH) + MW'(col));
  assign req_addr = AW'(MW'(item.read_row) * MW'(SCREEN_WIDTH) + MW'(item.read_column));
  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;

  assign result.valid         = out_valid;
  assign result.cell_value    = out_cell;
  assign result.cursor_row    = out_row;
  assign result.cursor_column = out_col;

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::S_INIT: begin
        if (ptr == PTR_LAST) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (item.valid) begin
          case (item.kind)
            tcw_pkg::KIND_PUT: begin
              if (item.char_code == tcw_pkg::CHAR_NEWLINE) begin
                state_next = (row == LAST_ROW) ? tcw_pkg::S_SCROLL : tcw_pkg::S_FINISH;
              end else if (item.char_code inside {tcw_pkg::CHAR_RETURN,
                                                  tcw_pkg::CHAR_NUL}) begin
                state_next = tcw_pkg::S_FINISH;
              end else begin
                state_next = tcw_pkg::S_GLYPH;
              end
            end
            tcw_pkg::KIND_CLEAR: state_next = tcw_pkg::S_CLEAR;
            tcw_pkg::KIND_READ:  state_next = tcw_pkg::S_READ;
            default:             state_next = tcw_pkg::S_FINISH;
          endcase
        end
      end
      tcw_pkg::S_GLYPH: begin
        if (col == WRAP_COL) begin
          if (row == LAST_ROW) state_next = tcw_pkg::S_SCROLL;
        end else if (glyph_left == 3'd1) begin
          state_next = tcw_pkg::S_FINISH;
        end
      end
      tcw_pkg::S_SCROLL: begin
        if (ptr == PTR_END) state_next = tcw_pkg::S_BLANK;
      end
      tcw_pkg::S_BLANK: begin
        if (ptr == PTR_LAST) begin
          state_next = (glyph_left != 3'd0) ? tcw_pkg::S_GLYPH : tcw_pkg::S_FINISH;
        end
      end
      tcw_pkg::S_CLEAR: begin
        if (ptr == PTR_LAST) state_next = tcw_pkg::S_FINISH;
      end
      tcw_pkg::S_READ:   state_next = tcw_pkg::S_FINISH;
      tcw_pkg::S_FINISH: begin
        if (out_free) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_INIT;
    endcase
  end

  // RAM control and input handshake
  always_comb begin
    item.ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = ptr[AW-1:0];
    mem_wdata  = {attribute, tcw_pkg::CHAR_SPACE};
    mem_raddr  = ptr[AW-1:0];
    case (state)
      tcw_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::RESET_CELL;
      end
      tcw_pkg::S_IDLE: begin
        item.ready = 1'b1;
        mem_raddr  = req_addr;
      end
      tcw_pkg::S_GLYPH: begin
        mem_we    = (col != WRAP_COL);
        mem_waddr = cur_addr;
        mem_wdata = {attribute, glyph_char};
      end
      tcw_pkg::S_SCROLL: begin
        // read cell ptr, write the cell read last cycle one row up
        mem_we    = (ptr != PTR_ROW1);
        mem_waddr = AW'(ptr - PTR_ROW1 - PW'(1));
        mem_wdata = mem_rdata;
      end
      tcw_pkg::S_BLANK, tcw_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::S_INIT;
      ptr        <= '0;
      row        <= '0;
      col        <= '0;
      glyph_left <= '0;
      attribute  <= tcw_pkg::ATTR_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) attribute <= cfg_wdata;
      // finish reloads the output register itself
      if (out_valid && result.ready && state != tcw_pkg::S_FINISH) out_valid <= 1'b0;

      case (state)
        tcw_pkg::S_INIT: begin
          ptr <= (ptr == PTR_LAST) ? '0 : ptr + PW'(1);
        end
        tcw_pkg::S_IDLE: begin
          if (accept) begin
            read_cell  <= '0;
            glyph_char <= item.char_code;
            glyph_left <= '0;
            in_range   <= (32'(item.read_row) < SCREEN_HEIGHT) &&
                          (32'(item.read_column) < SCREEN_WIDTH);
            case (item.kind)
              tcw_pkg::KIND_PUT: begin
                case (item.char_code)
                  tcw_pkg::CHAR_NEWLINE: begin
                    col <= '0;
                    if (row != LAST_ROW) row <= row + RW'(1);
                    else ptr <= PTR_ROW1;
                  end
                  tcw_pkg::CHAR_RETURN: col <= '0;
                  tcw_pkg::CHAR_TAB: begin
                    glyph_left <= 3'(tcw_pkg::TAB_STOP) - {1'b0, col[1:0]};
                    glyph_char <= tcw_pkg::CHAR_SPACE;
                  end
                  tcw_pkg::CHAR_NUL: begin
                  end
                  default: glyph_left <= 3'd1;
                endcase
              end
              tcw_pkg::KIND_CLEAR: begin
                row <= '0;
                col <= '0;
                ptr <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        tcw_pkg::S_GLYPH: begin
          if (col == WRAP_COL) begin
            // lazy wrap
            col <= '0;
            if (row != LAST_ROW) row <= row + RW'(1);
            else ptr <= PTR_ROW1;
          end else begin
            col        <= col + CW'(1);
            glyph_left <= glyph_left - 3'd1;
          end
        end
        tcw_pkg::S_SCROLL: begin
          ptr <= (ptr == PTR_END) ? PTR_BOTTOM : ptr + PW'(1);
        end
        tcw_pkg::S_BLANK, tcw_pkg::S_CLEAR: begin
          ptr <= ptr + PW'(1);
        end
        tcw_pkg::S_READ: begin
          if (in_range) read_cell <= mem_rdata;
        end
        tcw_pkg::S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_cell  <= read_cell;
            out_row   <= 5'(row);
            out_col   <= 7'(col);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= WRAP_COL)
    else $error("cursor column past wrap position");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    32'(row) < SCREEN_HEIGHT)
    else $error("cursor row off screen");

  a_quiet_ram: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_IDLE || state == tcw_pkg::S_FINISH) |-> !mem_we)
    else $error("screen write outside a write phase");

  a_scroll_order: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_SCROLL && mem_we && ptr != PTR_END) |-> mem_waddr < mem_raddr)
    else $error("scroll overwrites a cell not yet copied");

  a_glyph_count: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::S_GLYPH |-> (glyph_left != 3'd0 && glyph_left <= 3'd4))
    else $error("glyph count out of range");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == tcw_pkg::S_FINISH)
    else $error("result raised outside finish");

endmodule
